// ===== design/kas_pkg.sv =====
// Package for the keypad access sequencer: word types, codes and helpers.
`default_nettype none
package kas_pkg;

    localparam int CODE_DIGITS_DEF = 4;
    localparam int TICK_W          = 20;
    localparam int CFG_IDX_W       = 1;

    localparam logic [TICK_W-1:0] TICK_MAX      = {TICK_W{1'b1}};
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 20'd30000;
    localparam logic [TICK_W-1:0] DISPLAY_RESET = 20'd5000;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY = 1'b1;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_WAIT_BTN  = 3'd1;
    localparam logic [2:0] PH_ENTER     = 3'd2;
    localparam logic [2:0] PH_WAIT_CODE = 3'd3;
    localparam logic [2:0] PH_GRANTED   = 3'd4;
    localparam logic [2:0] PH_DENIED    = 3'd5;
    localparam logic [2:0] PH_ERROR     = 3'd6;

    localparam logic [2:0] LED_OFF    = 3'd0;
    localparam logic [2:0] LED_ORANGE = 3'd1;
    localparam logic [2:0] LED_GREEN  = 3'd2;
    localparam logic [2:0] LED_RED    = 3'd3;
    localparam logic [2:0] LED_BLUE   = 3'd4;

    localparam logic [1:0] SEND_NONE   = 2'd0;
    localparam logic [1:0] SEND_BUTTON = 2'd1;
    localparam logic [1:0] SEND_CODE   = 2'd2;

    localparam logic [1:0] REPLY_TRUE  = 2'd0;
    localparam logic [1:0] REPLY_FALSE = 2'd1;

    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [3:0] KEY_SUBMIT    = 4'd10;
    localparam logic [3:0] KEY_ERASE     = 4'd11;

    typedef struct packed {
        logic       button_level;
        logic       key_valid;
        logic [3:0] key_code;
        logic       reply_valid;
        logic       reply_feed;
        logic [1:0] reply_value;
        logic       send_ok;
    } in_t;

    typedef struct packed {
        logic [2:0]  phase_out;
        logic [2:0]  led_color;
        logic [1:0]  send_kind;
        logic [15:0] sent_code;
        logic [2:0]  entered_count;
    } out_t;

    function automatic logic [2:0] led_of(input logic [2:0] phase);
        logic [2:0] led;
        unique case (phase)
            PH_WAIT_BTN, PH_ENTER, PH_WAIT_CODE: led = LED_ORANGE;
            PH_GRANTED:                          led = LED_GREEN;
            PH_DENIED:                           led = LED_RED;
            PH_ERROR:                            led = LED_BLUE;
            default:                             led = LED_OFF;
        endcase
        return led;
    endfunction

    function automatic logic [2:0] reply_target(input logic [1:0] value,
                                                input logic [2:0] on_true);
        logic [2:0] target;
        priority if (value == REPLY_TRUE)
            target = on_true;
        else if (value == REPLY_FALSE)
            target = PH_DENIED;
        else
            target = PH_ERROR;
        return target;
    endfunction

endpackage
`default_nettype wire

// ===== design/kas_cfg.sv =====
// Configuration registers of the keypad access sequencer.
`default_nettype none
module kas_cfg
    import kas_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TICK_W-1:0]    cfg_data,
    output logic      [TICK_W-1:0]    timeout_ticks,
    output logic      [TICK_W-1:0]    display_ticks
);

    logic [TICK_W-1:0] timeout_reg;
    logic [TICK_W-1:0] display_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            display_reg <= DISPLAY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT: timeout_reg <= cfg_data;
                CFG_DISPLAY: display_reg <= cfg_data;
                default:     display_reg <= display_reg;
            endcase
        end
    end

    assign timeout_ticks = timeout_reg;
    assign display_ticks = display_reg;

endmodule
`default_nettype wire

// ===== design/kas_core.sv =====
// Phase state, elapsed counter, digit buffer and next-state logic for one word.
`default_nettype none
module kas_core
    import kas_pkg::*;
#(
    parameter int CODE_DIGITS = CODE_DIGITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire in_t               item,
    input  wire logic [TICK_W-1:0] timeout_ticks,
    input  wire logic [TICK_W-1:0] display_ticks,
    output out_t                   result
);

    localparam int CNT_W = $clog2(CODE_DIGITS + 1);
    localparam int IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(CODE_DIGITS);

    logic [2:0]        phase_reg,  phase_next;
    logic              last_btn_reg, last_btn_next;
    logic [TICK_W-1:0] ticks_reg,  ticks_next;
    logic [CNT_W-1:0]  held_reg,   held_next;
    logic [3:0]        digit_reg [CODE_DIGITS];
    logic              digit_we;
    logic [1:0]        kind;
    logic [15:0]       code;

    always_comb
    begin
        phase_next    = phase_reg;
        last_btn_next = last_btn_reg;
        held_next     = held_reg;
        digit_we      = 1'b0;
        kind          = SEND_NONE;
        code          = 16'd0;
        ticks_next    = (ticks_reg != TICK_MAX) ? ticks_reg + 1'b1 : ticks_reg;

        if (item.reply_valid && !item.reply_feed && phase_reg == PH_WAIT_BTN)
        begin
            phase_next = reply_target(item.reply_value, PH_ENTER);
            ticks_next = '0;
            if (phase_next == PH_ENTER)
                held_next = '0;
        end
        else if (item.reply_valid && item.reply_feed && phase_reg == PH_WAIT_CODE)
        begin
            phase_next = reply_target(item.reply_value, PH_GRANTED);
            ticks_next = '0;
        end

        unique case (phase_next)
            PH_IDLE:
            begin
                if (item.button_level && !last_btn_reg)
                begin
                    kind       = SEND_BUTTON;
                    phase_next = item.send_ok ? PH_WAIT_BTN : PH_ERROR;
                    ticks_next = '0;
                end
                last_btn_next = item.button_level;
            end
            PH_WAIT_BTN, PH_WAIT_CODE:
            begin
                if (ticks_next > timeout_ticks)
                begin
                    phase_next = PH_ERROR;
                    ticks_next = '0;
                end
            end
            PH_ENTER:
            begin
                if (item.key_valid)
                begin
                    priority if (item.key_code == KEY_SUBMIT)
                    begin
                        if (held_next == FULL)
                        begin
                            for (int i = 0; i < CODE_DIGITS; i++)
                                code = {code[11:0], digit_reg[i]};
                            kind       = SEND_CODE;
                            held_next  = '0;
                            phase_next = item.send_ok ? PH_WAIT_CODE : PH_ERROR;
                            ticks_next = '0;
                        end
                    end
                    else if (item.key_code == KEY_ERASE)
                        held_next = '0;
                    else if (item.key_code <= KEY_DIGIT_MAX && held_next < FULL)
                    begin
                        digit_we  = 1'b1;
                        held_next = held_next + 1'b1;
                    end
                end
                if (phase_next == PH_ENTER && ticks_next > timeout_ticks)
                begin
                    held_next  = '0;
                    phase_next = PH_ERROR;
                    ticks_next = '0;
                end
            end
            PH_GRANTED, PH_DENIED, PH_ERROR:
            begin
                if (ticks_next >= display_ticks)
                begin
                    phase_next = PH_IDLE;
                    ticks_next = '0;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                ticks_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            last_btn_reg <= 1'b0;
            ticks_reg    <= '0;
            held_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            last_btn_reg <= last_btn_next;
            ticks_reg    <= ticks_next;
            held_reg     <= held_next;
        end
    end

    // write slot follows the count as it stood before this word
    always_ff @(posedge clk)
    begin
        if (step && digit_we)
            digit_reg[held_reg[IDX_W-1:0]] <= item.key_code;
    end

    always_comb
    begin
        result.phase_out     = phase_next;
        result.led_color     = led_of(phase_next);
        result.send_kind     = kind;
        result.sent_code     = code;
        result.entered_count = 3'(held_next);
    end

endmodule
`default_nettype wire

// ===== design/keypad_access_sequencer.sv =====
// Top level of the keypad access sequencer: input and result registers, handshake.
//
//   channel  | direction | handshake            | word
//   ---------+-----------+----------------------+--------------------------
//   in       | in        | in_valid / in_stall  | in_data  (kas_pkg::in_t)
//   out      | out       | out_valid / out_stall| out_data (kas_pkg::out_t)
//   cfg      | in        | cfg_we               | cfg_index, cfg_data
//
// One word per cycle sustained while out_stall is low; one result word per input word.
// A word taken sits in the input register; its result is computed by the phase
// logic and registered into the result register once that register is free.
// Reset clears phase, counters and registers to 30000 and 5000 ticks;
// the digit buffer holds no reset value.
// out_stall holds the result word; in_stall rises only when both registers
// are full and the result is stalled.
`default_nettype none
module keypad_access_sequencer
    import kas_pkg::*;
#(
    parameter int CODE_DIGITS = CODE_DIGITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire in_t                  in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output out_t                      out_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TICK_W-1:0]    cfg_data
);

    logic              s1_valid_reg, s1_valid_next;
    in_t               s1_data_reg;
    logic              out_valid_reg, out_valid_next;
    out_t              out_data_reg;
    out_t              result;
    logic              advance;
    logic              in_take;
    logic              fire;
    logic [TICK_W-1:0] timeout_ticks;
    logic [TICK_W-1:0] display_ticks;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;
    assign fire     = s1_valid_reg && advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (fire)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_data_reg <= in_data;
        if (fire)
            out_data_reg <= result;
    end

    kas_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .timeout_ticks (timeout_ticks),
        .display_ticks (display_ticks)
    );

    kas_core #(
        .CODE_DIGITS (CODE_DIGITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (fire),
        .item          (s1_data_reg),
        .timeout_ticks (timeout_ticks),
        .display_ticks (display_ticks),
        .result        (result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

// ===== design/kas_checker.sv =====
// Port-level checks for the keypad access sequencer, bound to the top level.
`default_nettype none
module kas_checker
    import kas_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_stall,
    input wire in_t                  in_data,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire out_t                 out_data
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("input word changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    a_code_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.send_kind == SEND_CODE |->
            out_data.phase_out == PH_WAIT_CODE || out_data.phase_out == PH_ERROR)
        else $error("code submission left a wrong phase");

    a_button_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.send_kind == SEND_BUTTON |->
            out_data.phase_out == PH_WAIT_BTN || out_data.phase_out == PH_ERROR)
        else $error("button request left a wrong phase");

    a_code_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.send_kind != SEND_CODE |->
            out_data.sent_code == 16'd0 &&
            (out_data.phase_out != PH_IDLE || out_data.entered_count == 3'd0))
        else $error("stale code or digit count shown");

endmodule

bind keypad_access_sequencer kas_checker u_kas_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
`default_nettype wire

// ===== sim/kas_access_check.sv =====
// Checker for the keypad access sequencer: predicts every result word and compares it.
module kas_access_check
    import kas_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  in_t                  in_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  out_t                 out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_data,
    output int                   fail_count,
    output int                   pending
);

    localparam int BUF_IDX_W = (CODE_DIGITS_DEF > 1) ? $clog2(CODE_DIGITS_DEF) : 1;

    logic [TICK_W-1:0] lim_timeout;
    logic [TICK_W-1:0] lim_display;
    logic [2:0]        cur_phase;
    logic              prev_button;
    logic [TICK_W-1:0] elapsed;
    logic [3:0]        digit_buf [CODE_DIGITS_DEF];
    logic [2:0]        digit_count;
    out_t              expected_words [$];

    function automatic logic [2:0] led_for_phase(input logic [2:0] p);
        case (p)
            PH_WAIT_BTN, PH_ENTER, PH_WAIT_CODE:
                return LED_ORANGE;
            PH_GRANTED:
                return LED_GREEN;
            PH_DENIED:
                return LED_RED;
            PH_ERROR:
                return LED_BLUE;
            default:
                return LED_OFF;
        endcase
    endfunction

    function automatic logic [2:0] reply_outcome(input logic [1:0] v, input logic [2:0] on_true);
        if (v == REPLY_TRUE)
            return on_true;
        if (v == REPLY_FALSE)
            return PH_DENIED;
        return PH_ERROR;
    endfunction

    function automatic void enter_phase(input logic [2:0] p);
        cur_phase = p;
        elapsed = '0;
        if (p == PH_ENTER)
            digit_count = '0;
    endfunction

    function automatic out_t predict_sequencer(input in_t w);
        out_t        r;
        logic [1:0]  kind;
        logic [15:0] code;
        kind = SEND_NONE;
        code = '0;
        if (elapsed != TICK_MAX)
            elapsed++;
        if (w.reply_valid)
        begin
            if (!w.reply_feed && cur_phase == PH_WAIT_BTN)
                enter_phase(reply_outcome(w.reply_value, PH_ENTER));
            else if (w.reply_feed && cur_phase == PH_WAIT_CODE)
                enter_phase(reply_outcome(w.reply_value, PH_GRANTED));
        end
        case (cur_phase)
            PH_IDLE:
            begin
                if (w.button_level && !prev_button)
                begin
                    kind = SEND_BUTTON;
                    enter_phase(w.send_ok ? PH_WAIT_BTN : PH_ERROR);
                end
                prev_button = w.button_level;
            end
            PH_WAIT_BTN, PH_WAIT_CODE:
            begin
                if (elapsed > lim_timeout)
                    enter_phase(PH_ERROR);
            end
            PH_ENTER:
            begin
                if (w.key_valid)
                begin
                    if (w.key_code == KEY_SUBMIT)
                    begin
                        if (digit_count == CODE_DIGITS_DEF)
                        begin
                            for (int i = 0; i < CODE_DIGITS_DEF; i++)
                                code = {code[11:0], digit_buf[i]};
                            kind = SEND_CODE;
                            digit_count = '0;
                            enter_phase(w.send_ok ? PH_WAIT_CODE : PH_ERROR);
                        end
                    end
                    else if (w.key_code == KEY_ERASE)
                        digit_count = '0;
                    else if (w.key_code <= KEY_DIGIT_MAX && digit_count < CODE_DIGITS_DEF)
                    begin
                        digit_buf[digit_count[BUF_IDX_W-1:0]] = w.key_code;
                        digit_count++;
                    end
                end
                if (cur_phase == PH_ENTER && elapsed > lim_timeout)
                begin
                    digit_count = '0;
                    enter_phase(PH_ERROR);
                end
            end
            PH_GRANTED, PH_DENIED, PH_ERROR:
            begin
                if (elapsed >= lim_display)
                    enter_phase(PH_IDLE);
            end
            default:
                enter_phase(PH_IDLE);
        endcase
        r.phase_out = cur_phase;
        r.led_color = led_for_phase(cur_phase);
        r.send_kind = kind;
        r.sent_code = code;
        r.entered_count = digit_count;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    task automatic check_word(input out_t got);
        out_t want;
        if (expected_words.size() == 0)
        begin
            report_mismatch("word with nothing expected, phase_out", int'(got.phase_out), -1);
            return;
        end
        want = expected_words.pop_front();
        if (got.phase_out !== want.phase_out)
            report_mismatch("phase_out", int'(got.phase_out), int'(want.phase_out));
        if (got.led_color !== want.led_color)
            report_mismatch("led_color", int'(got.led_color), int'(want.led_color));
        if (got.send_kind !== want.send_kind)
            report_mismatch("send_kind", int'(got.send_kind), int'(want.send_kind));
        if (got.sent_code !== want.sent_code)
            report_mismatch("sent_code", int'(got.sent_code), int'(want.sent_code));
        if (got.entered_count !== want.entered_count)
            report_mismatch("entered_count", int'(got.entered_count),
                            int'(want.entered_count));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_timeout = TIMEOUT_RESET;
            lim_display = DISPLAY_RESET;
            cur_phase = PH_IDLE;
            prev_button = 1'b0;
            elapsed = '0;
            digit_count = '0;
            expected_words.delete();
            pending = 0;
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_TIMEOUT)
                    lim_timeout = cfg_data;
                else if (cfg_index == CFG_DISPLAY)
                    lim_display = cfg_data;
            end
            if (out_valid && !out_stall)
                check_word(out_data);
            if (in_valid && !in_stall)
                expected_words.push_back(predict_sequencer(in_data));
            pending = expected_words.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
// Testbench top for the keypad access sequencer: clock, reset, stimulus and verdict.
module testbench;
    import kas_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 60;
    localparam int IN_W        = $bits(in_t);

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_t                  in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_t                 out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TICK_W-1:0]    cfg_data;
    int                   fail_count;
    int                   pending;
    int                   send_gap_pct;
    int                   recv_hold_pct;
    int                   hold_asked;
    int                   sent_total;

    keypad_access_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    kas_access_check seq_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic in_t make_word(input logic btn, input logic kv, input logic [3:0] key,
                                      input logic rv, input logic feed,
                                      input logic [1:0] val, input logic sok);
        in_t w;
        w.button_level = btn;
        w.key_valid = kv;
        w.key_code = key;
        w.reply_valid = rv;
        w.reply_feed = feed;
        w.reply_value = val;
        w.send_ok = sok;
        return w;
    endfunction

    function automatic in_t random_word();
        logic [IN_W-1:0] bits;
        bits = IN_W'($urandom);
        return in_t'(bits);
    endfunction

    function automatic logic [1:0] pick_reply();
        int roll;
        roll = $urandom_range(9);
        if (roll < 7)
            return REPLY_TRUE;
        if (roll == 7)
            return REPLY_FALSE;
        return 2'(roll - 6);
    endfunction

    task automatic send_word(input in_t w);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do
            @(posedge clk);
        while (in_stall);
        sent_total++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_limits(input logic [TICK_W-1:0] timeout, input logic [TICK_W-1:0] display);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= CFG_TIMEOUT;
        cfg_data <= timeout;
        @(negedge clk);
        cfg_index <= CFG_DISPLAY;
        cfg_data <= display;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int budget);
        int         start;
        int         n;
        int         roll;
        logic [3:0] key;
        start = sent_total;
        while (sent_total - start < budget)
        begin
            if ($urandom_range(99) < 15)
            begin
                repeat ($urandom_range(5, 1)) send_word(random_word());
            end
            else
            begin
                send_word(make_word(1'b0, 1'b0, 4'($urandom_range(15)), 1'b0, 1'b0, 2'd0,
                                    1'b1));
                send_word(make_word(1'b1, 1'b0, 4'd0, 1'b0, 1'b0, 2'd0,
                                    $urandom_range(9) != 0));
                send_word(make_word(1'b1, 1'b0, 4'd0, 1'b1, 1'b0, pick_reply(), 1'b1));
                n = $urandom_range(6, 4);
                for (int i = 0; i < n; i++)
                begin
                    roll = $urandom_range(19);
                    if (roll < 15)
                        key = 4'($urandom_range(9));
                    else if (roll == 15)
                        key = KEY_ERASE;
                    else if (roll == 16)
                        key = KEY_SUBMIT;
                    else
                        key = 4'($urandom_range(15, 12));
                    send_word(make_word(1'($urandom_range(1)), roll != 19, key,
                                        1'b0, 1'b0, 2'd0, 1'b1));
                end
                send_word(make_word(1'($urandom_range(1)), 1'b1, KEY_SUBMIT, 1'b0, 1'b0,
                                    2'd0, $urandom_range(9) != 0));
                send_word(make_word(1'b0, 1'b0, 4'd0, 1'b1, 1'b1, pick_reply(), 1'b1));
                repeat ($urandom_range(6, 1))
                    send_word(make_word(1'($urandom_range(1)), 1'b0,
                                        4'($urandom_range(15)), 1'b0,
                                        1'($urandom_range(1)), 2'($urandom_range(3)),
                                        1'($urandom_range(1))));
            end
        end
    endtask

    // hold the result side for a long stretch on request, otherwise stall at random
    initial
    begin
        int hold_served;
        int hold_left;
        hold_served = 0;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && hold_served < hold_asked)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_hold_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_TIMEOUT;
        cfg_data = '0;
        send_gap_pct = 38;
        recv_hold_pct = 67;
        hold_asked = 0;
        sent_total = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_limits(20'd12, 20'd3);
        send_word(make_word(1'b0, 1'b0, 4'd0, 1'b0, 1'b0, REPLY_TRUE, 1'b1));
        send_word(make_word(1'b1, 1'b0, 4'd0, 1'b0, 1'b0, REPLY_TRUE, 1'b1));
        // code reply while waiting for the button reply: drop it
        send_word(make_word(1'b1, 1'b0, 4'd0, 1'b1, 1'b1, REPLY_TRUE, 1'b1));
        send_word(make_word(1'b0, 1'b0, 4'd0, 1'b1, 1'b0, REPLY_TRUE, 1'b1));
        send_word(make_word(1'b0, 1'b1, 4'd15, 1'b0, 1'b0, REPLY_TRUE, 1'b1));
        send_word(make_word(1'b0, 1'b1, KEY_DIGIT_MAX, 1'b0, 1'b0, REPLY_TRUE, 1'b1));
        send_word(make_word(1'b0, 1'b1, KEY_SUBMIT, 1'b0, 1'b0, REPLY_TRUE, 1'b1));
        send_word(make_word(1'b0, 1'b1, KEY_ERASE, 1'b0, 1'b0, REPLY_TRUE, 1'b1));
        send_word(make_word(1'b0, 1'b1, KEY_DIGIT_MAX, 1'b0, 1'b0, REPLY_TRUE, 1'b1));
        send_word(make_word(1'b0, 1'b1, 4'd0, 1'b0, 1'b0, REPLY_TRUE, 1'b1));
        send_word(make_word(1'b0, 1'b1, 4'd5, 1'b0, 1'b0, REPLY_TRUE, 1'b1));
        send_word(make_word(1'b0, 1'b1, 4'd3, 1'b0, 1'b0, REPLY_TRUE, 1'b1));
        send_word(make_word(1'b0, 1'b1, 4'd8, 1'b0, 1'b0, REPLY_TRUE, 1'b1));
        send_word(make_word(1'b0, 1'b1, KEY_SUBMIT, 1'b0, 1'b0, REPLY_TRUE, 1'b1));
        send_word(make_word(1'b0, 1'b0, 4'd0, 1'b1, 1'b1, REPLY_TRUE, 1'b1));
        // keep the button pressed through the display time: no edge back in idle
        repeat (4) send_word(make_word(1'b1, 1'b0, 4'd0, 1'b0, 1'b0, REPLY_TRUE, 1'b1));
        send_word(make_word(1'b0, 1'b0, 4'd0, 1'b0, 1'b0, REPLY_TRUE, 1'b1));
        send_word(make_word(1'b1, 1'b0, 4'd0, 1'b0, 1'b0, REPLY_TRUE, 1'b0));

        set_limits(20'd1, 20'd1);
        run_phase(250);
        set_limits(TICK_MAX, TICK_MAX);
        run_phase(100);

        send_gap_pct = 67;
        recv_hold_pct = 38;
        set_limits(20'd12, 20'd4);
        hold_asked++;
        run_phase(400);
        set_limits(20'd0, 20'd0);
        run_phase(150);

        send_gap_pct = 0;
        recv_hold_pct = 0;
        set_limits(20'd9, 20'd2);
        hold_asked++;
        run_phase(450);

        wait_drained();
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
